>>> rtl/hria_pkg.sv
// Package for the heart rate interval averager.
// Holds the fixed field widths and rate constants; no dependencies.
package hria_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned REFR_W = 16;
  localparam int unsigned BPM_W  = 16;

  // Beats per minute for one interval of one ms, and the saturation ceiling.
  localparam int unsigned RATE_SCALE = 60000;
  localparam int unsigned RATE_MAX   = 60000;

  localparam logic [REFR_W-1:0] REFR_RESET = 16'd300;

endpackage

>>> rtl/hria_addsub.sv
// Shared adder/subtractor of the heart rate interval averager.
// Standalone; used by heart_rate_interval_averager for the distance, refractory check, sum and divide.
module hria_addsub #(
  parameter int unsigned W = 36
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o,
  output logic         carry_o
);

  logic [W-1:0] b_eff;

  // Subtract as a + ~b + 1; carry out high means no borrow.
  assign b_eff = sub_i ? ~b_i : b_i;
  assign {carry_o, res_o} = {1'b0, a_i} + {1'b0, b_eff} + {{W{1'b0}}, sub_i};

endmodule

>>> rtl/heart_rate_interval_averager.sv
// Heart rate interval averager: edge timestamps in, interval and beat rate out.
// Steps per edge: the distance to the last edge and the refractory check on the
// shared adder; once WINDOW intervals are stored, a summing pass and a bit-serial
// restoring divide of 60000*WINDOW by the sum on the same adder (NUM_W = bits of
// 60000*WINDOW, 18 for WINDOW = 3). The first edge only records its time.
// One word at a time; the next word is taken once the result is in the output
// register, even while that result waits. Async active-low reset clears every
// register but the interval ring and loads the refractory register refr_q with 300.
// Depends on hria_pkg and hria_addsub.
module heart_rate_interval_averager #(
  parameter int unsigned WINDOW = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [hria_pkg::REFR_W-1:0]  cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [hria_pkg::TIME_W-1:0]  edge_time_ms_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         interval_accepted_o,
  output logic [hria_pkg::TIME_W-1:0]  interval_ms_o,
  output logic                         rate_valid_o,
  output logic [hria_pkg::BPM_W-1:0]   beats_per_minute_o
);

  localparam int unsigned TIME_W = hria_pkg::TIME_W;
  // The sum of WINDOW intervals; one more bit for the divider's shifted remainder.
  localparam int unsigned SUM_W  = TIME_W + $clog2(WINDOW);
  localparam int unsigned ALU_W  = SUM_W + 1;
  localparam int unsigned NUM    = hria_pkg::RATE_SCALE * WINDOW;
  localparam int unsigned NUM_W  = $clog2(NUM + 1);
  localparam int unsigned DCNT_W = $clog2(NUM_W);
  localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIST,
    S_CHECK,
    S_SUM,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q;

  logic [hria_pkg::REFR_W-1:0] refr_q;
  logic [TIME_W-1:0]           t_q;
  logic [TIME_W-1:0]           last_q;
  logic                        have_prev_q;
  logic [TIME_W-1:0]           dist_q;
  logic [TIME_W-1:0]           ring_q [WINDOW];
  logic [PTR_W-1:0]            ptr_q;
  logic [CNT_W-1:0]            fill_q;
  logic [PTR_W-1:0]            idx_q;
  logic [SUM_W-1:0]            acc_q;
  logic [SUM_W-1:0]            rem_q;
  logic [NUM_W-1:0]            num_q;
  logic [DCNT_W-1:0]           dcnt_q;
  logic                        acc_flag_q;
  logic [TIME_W-1:0]           intv_q;
  logic                        rvalid_q;

  logic                        out_valid_q;
  logic                        out_acc_q;
  logic [TIME_W-1:0]           out_intv_q;
  logic                        out_rvalid_q;
  logic [hria_pkg::BPM_W-1:0]  out_bpm_q;

  // Shared adder.
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic             alu_sub;
  logic [ALU_W-1:0] alu_res;
  logic             alu_carry;

  hria_addsub #(.W(ALU_W)) u_addsub (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sub_i  (alu_sub),
    .res_o  (alu_res),
    .carry_o(alu_carry)
  );

  logic [ALU_W-1:0] rem_shift;
  assign rem_shift = {rem_q, num_q[NUM_W-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_q)
      S_DIST: begin
        // distance modulo 2^32 comes from the low bits
        alu_a = ALU_W'(t_q);
        alu_b = ALU_W'(last_q);
      end
      S_CHECK: begin
        // refractory - distance: a borrow means distance > refractory
        alu_a = ALU_W'(refr_q);
        alu_b = ALU_W'(dist_q);
      end
      S_SUM: begin
        alu_a   = ALU_W'(acc_q);
        alu_b   = ALU_W'(ring_q[idx_q]);
        alu_sub = 1'b0;
      end
      S_DIV: begin
        alu_a = rem_shift;
        alu_b = ALU_W'(acc_q);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  logic             accept_in;
  logic             out_free;
  logic             load_out;
  logic             dist_ok;
  logic [CNT_W-1:0] fill_upd;
  logic [NUM_W-1:0] num_next;
  logic [hria_pkg::BPM_W-1:0] bpm_sat;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept_in  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (state_q == S_DONE) && out_free;
  assign dist_ok    = !alu_carry;
  assign fill_upd   = (fill_q == CNT_W'(WINDOW)) ? fill_q : fill_q + CNT_W'(1);
  assign num_next   = {num_q[NUM_W-2:0], alu_carry};
  // Clamp the quotient to the rate ceiling.
  assign bpm_sat    = (num_q > NUM_W'(hria_pkg::RATE_MAX)) ?
                      hria_pkg::BPM_W'(hria_pkg::RATE_MAX) : hria_pkg::BPM_W'(num_q);

  // Store the interval of an accepted edge; the ring needs no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CHECK && dist_ok) begin
      ring_q[ptr_q] <= dist_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      refr_q       <= hria_pkg::REFR_RESET;
      t_q          <= '0;
      last_q       <= '0;
      have_prev_q  <= 1'b0;
      dist_q       <= '0;
      ptr_q        <= '0;
      fill_q       <= '0;
      idx_q        <= '0;
      acc_q        <= '0;
      rem_q        <= '0;
      num_q        <= '0;
      dcnt_q       <= '0;
      acc_flag_q   <= 1'b0;
      intv_q       <= '0;
      rvalid_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_acc_q    <= 1'b0;
      out_intv_q   <= '0;
      out_rvalid_q <= 1'b0;
      out_bpm_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        refr_q <= cfg_wdata_i;
      end
      // load a new word, else drop the one just taken
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept_in) begin
            t_q        <= edge_time_ms_i;
            acc_flag_q <= 1'b0;
            intv_q     <= '0;
            if (!have_prev_q) begin
              // first edge: record the time only
              last_q      <= edge_time_ms_i;
              have_prev_q <= 1'b1;
              rvalid_q    <= (fill_q == CNT_W'(WINDOW));
              acc_q       <= '0;
              idx_q       <= '0;
              state_q     <= (fill_q == CNT_W'(WINDOW)) ? S_SUM : S_DONE;
            end else begin
              state_q <= S_DIST;
            end
          end
        end
        S_DIST: begin
          dist_q  <= alu_res[TIME_W-1:0];
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          acc_q <= '0;
          idx_q <= '0;
          if (dist_ok) begin
            // advance the ring and move the reference time
            ptr_q         <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
            fill_q        <= fill_upd;
            last_q        <= t_q;
            acc_flag_q    <= 1'b1;
            intv_q        <= dist_q;
            rvalid_q      <= (fill_upd == CNT_W'(WINDOW));
            state_q       <= (fill_upd == CNT_W'(WINDOW)) ? S_SUM : S_DONE;
          end else begin
            rvalid_q <= (fill_q == CNT_W'(WINDOW));
            state_q  <= (fill_q == CNT_W'(WINDOW)) ? S_SUM : S_DONE;
          end
        end
        S_SUM: begin
          acc_q <= alu_res[SUM_W-1:0];
          idx_q <= idx_q + PTR_W'(1);
          if (idx_q == PTR_W'(WINDOW - 1)) begin
            rem_q   <= '0;
            num_q   <= NUM_W'(NUM);
            dcnt_q  <= DCNT_W'(NUM_W - 1);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring step: keep the trial remainder when it did not borrow
          rem_q  <= alu_carry ? alu_res[SUM_W-1:0] : rem_shift[SUM_W-1:0];
          num_q  <= num_next;
          dcnt_q <= dcnt_q - DCNT_W'(1);
          if (dcnt_q == '0) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_acc_q    <= acc_flag_q;
            out_intv_q   <= intv_q;
            out_rvalid_q <= rvalid_q;
            out_bpm_q    <= rvalid_q ? bpm_sat : '0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign interval_accepted_o = out_acc_q;
  assign interval_ms_o       = out_intv_q;
  assign rate_valid_o        = out_rvalid_q;
  assign beats_per_minute_o  = out_bpm_q;

  // Fill count saturates at the window size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW))
    else $error("fill count above window");

  // Ring pointer stays within the ring.
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(WINDOW - 1))
    else $error("ring pointer out of range");

  // No rate is reported before the window is full.
  a_rate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !rate_valid_o) |-> (beats_per_minute_o == '0))
    else $error("rate reported while not valid");

  // A rejected edge reports no interval.
  a_intv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !interval_accepted_o) |-> (interval_ms_o == '0))
    else $error("interval reported for rejected edge");

  // The reported rate never exceeds the ceiling.
  a_rate_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (beats_per_minute_o <= hria_pkg::BPM_W'(hria_pkg::RATE_MAX)))
    else $error("rate above ceiling");

endmodule
